// ===== rtl/mm2_pkg.sv =====
package mm2_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;
    localparam logic [2:0]  FULL_COUNT  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_KEY2,
        ST_HASH,
        ST_TAIL,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_KEY,
        OP_KEY2,
        OP_HASH,
        OP_TAIL,
        OP_FIN
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/mm2_datapath.sv =====
module mm2_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [31:0]         seed,
    input  logic [31:0]         key_word,
    input  logic [2:0]          byte_count,
    input  logic                first_word,
    input  logic                last_word,
    input  logic [30:0]         key_length,
    input  logic                out_stall,
    input  mm2_pkg::cmd_t       cmd,
    output mm2_pkg::status_t    status,
    output logic                out_valid,
    output logic [31:0]         hash_value
);

    logic [31:0] seed_reg;
    logic [31:0] h_reg;
    logic [31:0] k_reg;
    logic [31:0] w_reg;
    logic [2:0]  cnt_reg;
    logic        last_reg;
    logic        out_valid_reg;
    logic [31:0] hash_reg;

    logic [31:0] h_next;
    logic [31:0] k_next;
    logic [31:0] tail_mask;
    logic [31:0] mult_a;
    logic [31:0] prod;

    always_comb
    begin
        case (cnt_reg)
            3'd1:    tail_mask = 32'h0000_00ff;
            3'd2:    tail_mask = 32'h0000_ffff;
            default: tail_mask = 32'h00ff_ffff;
        endcase
    end

    always_comb
    begin
        case (cmd.op)
            mm2_pkg::OP_KEY:  mult_a = w_reg;
            mm2_pkg::OP_KEY2: mult_a = k_reg ^ (k_reg >> mm2_pkg::MIX_SHIFT);
            mm2_pkg::OP_HASH: mult_a = h_reg;
            mm2_pkg::OP_TAIL: mult_a = h_reg ^ (w_reg & tail_mask);
            mm2_pkg::OP_FIN:  mult_a = h_reg ^ (h_reg >> mm2_pkg::FIN_SHIFT_A);
            default:          mult_a = h_reg;
        endcase
    end

    assign prod = 32'(mult_a * mm2_pkg::MIX_MUL);

    always_comb
    begin
        h_next = h_reg;
        k_next = k_reg;
        if (cmd.load)
        begin
            if (first_word)
            begin
                h_next = seed_reg ^ {1'b0, key_length};
            end
        end
        case (cmd.op)
            mm2_pkg::OP_KEY:  k_next = prod;
            mm2_pkg::OP_KEY2: k_next = prod;
            mm2_pkg::OP_HASH: h_next = prod ^ k_reg;
            mm2_pkg::OP_TAIL: h_next = prod;
            mm2_pkg::OP_FIN:  k_next = prod;
            default:          ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= 32'd0;
            h_reg         <= 32'd0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                seed_reg <= seed;
            end
            h_reg <= h_next;
            if (cmd.load)
            begin
                last_reg <= last_word;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        if (cmd.load)
        begin
            w_reg   <= key_word;
            cnt_reg <= byte_count;
        end
        if (cmd.out_load)
        begin
            hash_reg <= k_reg ^ (k_reg >> mm2_pkg::FIN_SHIFT_B);
        end
    end

    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign hash_value      = hash_reg;

endmodule

// ===== rtl/mm2_ctrl.sv =====
module mm2_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [2:0]          byte_count,
    input  logic                last_word,
    input  mm2_pkg::status_t    status,
    output mm2_pkg::cmd_t       cmd,
    output logic                in_stall
);

    mm2_pkg::state_t state_reg;
    mm2_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mm2_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_count >= mm2_pkg::FULL_COUNT)
                    begin
                        state_next = mm2_pkg::ST_KEY;
                    end
                    else if (byte_count != 3'd0)
                    begin
                        state_next = mm2_pkg::ST_TAIL;
                    end
                    else if (last_word)
                    begin
                        state_next = mm2_pkg::ST_FIN;
                    end
                end
            end
            mm2_pkg::ST_KEY:  state_next = mm2_pkg::ST_KEY2;
            mm2_pkg::ST_KEY2: state_next = mm2_pkg::ST_HASH;
            mm2_pkg::ST_HASH,
            mm2_pkg::ST_TAIL:
            begin
                state_next = status.last ? mm2_pkg::ST_FIN : mm2_pkg::ST_IDLE;
            end
            mm2_pkg::ST_FIN:  state_next = mm2_pkg::ST_OUT;
            mm2_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = mm2_pkg::ST_IDLE;
                end
            end
            default: state_next = mm2_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load     = 1'b0;
        cmd.op       = mm2_pkg::OP_NONE;
        cmd.out_load = 1'b0;
        in_stall     = 1'b1;
        case (state_reg)
            mm2_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            mm2_pkg::ST_KEY:  cmd.op = mm2_pkg::OP_KEY;
            mm2_pkg::ST_KEY2: cmd.op = mm2_pkg::OP_KEY2;
            mm2_pkg::ST_HASH: cmd.op = mm2_pkg::OP_HASH;
            mm2_pkg::ST_TAIL: cmd.op = mm2_pkg::OP_TAIL;
            mm2_pkg::ST_FIN:  cmd.op = mm2_pkg::OP_FIN;
            mm2_pkg::ST_OUT:  cmd.out_load = status.out_free;
            default:          ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mm2_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/murmur2_hash_stream.sv =====
// Streaming 32-bit MurmurHash2 of a byte key.
// Input channel (in_valid / in_stall): one request per little-endian key word,
// with byte_count, first_word, last_word and, on the first word, key_length.
// A request is taken when in_valid is high and in_stall is low.
// Configuration channel (cfg_valid / cfg_ready): writes the seed; always ready.
// Write it only while no key is in progress.
// Output channel (out_valid / out_stall): one hash_value per last word.
// Every multiply goes through one shared 32x32 multiplier, one per cycle:
// a full word uses ST_KEY, ST_KEY2 and ST_HASH, a partial word ST_TAIL, and an
// empty word none; a last word adds ST_FIN, then ST_OUT fills the output register.
// The output register frees the input side: the next key's words are taken
// while a finished hash waits; only a further hash waits for it to be taken.
// Stalling the output holds hash_value and out_valid unchanged.
// Reset clears the seed and running hash to zero and empties the output.
module murmur2_hash_stream
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] seed,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] key_word,
    input  logic [2:0]  byte_count,
    input  logic        first_word,
    input  logic        last_word,
    input  logic [30:0] key_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value
);

    mm2_pkg::cmd_t    cmd;
    mm2_pkg::status_t status;

    assign cfg_ready = 1'b1;

    mm2_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .byte_count (byte_count),
        .last_word  (last_word),
        .status     (status),
        .cmd        (cmd),
        .in_stall   (in_stall)
    );

    mm2_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .seed       (seed),
        .key_word   (key_word),
        .byte_count (byte_count),
        .first_word (first_word),
        .last_word  (last_word),
        .key_length (key_length),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .hash_value (hash_value)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  count;
        logic        first;
        logic        last;
        logic [30:0] len;
        logic        typed;
        logic [31:0] hash;
    } word_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] seed = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] key_word = '0;
    logic [2:0]  byte_count = '0;
    logic        first_word = 1'b0;
    logic        last_word = 1'b0;
    logic [30:0] key_length = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] hash_value;

    logic [31:0] seed_model = '0;
    logic [31:0] hash_acc = '0;
    logic [31:0] hash_due [$];
    logic [31:0] hash_want;
    int          fails = 0;
    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_out_req = 1'b0;
    int          quiet_cycles = 0;

    word_req_t dir_reqs [20] = '{
        '{32'h0000_0000, 3'd0, 1'b1, 1'b1, 31'd0,          1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, 31'd0,          1'b0, 32'h0},
        '{32'h0000_0000, 3'd4, 1'b0, 1'b1, 31'd0,          1'b0, 32'h0},
        '{32'hDEAD_BEEF, 3'd4, 1'b1, 1'b1, 31'd4,          1'b0, 32'h0},
        '{32'h0302_0100, 3'd4, 1'b1, 1'b0, 31'd7,          1'b0, 32'h0},
        '{32'hFFFF_FFFF, 3'd3, 1'b0, 1'b1, 31'd0,          1'b0, 32'h0},
        '{32'hFFFF_FFFF, 3'd1, 1'b1, 1'b1, 31'd1,          1'b0, 32'h0},
        '{32'hFFFF_FFFF, 3'd2, 1'b1, 1'b1, 31'd2,          1'b0, 32'h0},
        '{32'h1234_5678, 3'd7, 1'b1, 1'b0, 31'h7FFF_FFFF,  1'b0, 32'h0},
        '{32'h9ABC_DEF0, 3'd5, 1'b0, 1'b0, 31'd0,          1'b0, 32'h0},
        '{32'hFFFF_FFFF, 3'd6, 1'b0, 1'b1, 31'd0,          1'b0, 32'h0},
        '{32'hA5A5_A5A5, 3'd1, 1'b1, 1'b0, 31'd9,          1'b0, 32'h0},
        '{32'h5A5A_5A5A, 3'd4, 1'b0, 1'b0, 31'd0,          1'b0, 32'h0},
        '{32'hFFFF_FFFF, 3'd2, 1'b0, 1'b1, 31'd0,          1'b0, 32'h0},
        '{32'h8000_0001, 3'd4, 1'b1, 1'b0, 31'd4,          1'b0, 32'h0},
        '{32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 31'd0,          1'b0, 32'h0},
        '{32'hFFFF_FFFF, 3'd0, 1'b0, 1'b1, 31'd0,          1'b0, 32'h0},
        '{32'h00FF_00FF, 3'd3, 1'b0, 1'b1, 31'd0,          1'b0, 32'h0},
        '{32'h0000_0000, 3'd0, 1'b1, 1'b1, 31'h7FFF_FFFF,  1'b0, 32'h0},
        '{32'h7FFF_FFFF, 3'd0, 1'b0, 1'b0, 31'h2AAA_AAAA,  1'b0, 32'h0}
    };

    murmur2_hash_stream DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .seed       (seed),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_word   (key_word),
        .byte_count (byte_count),
        .first_word (first_word),
        .last_word  (last_word),
        .key_length (key_length),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [31:0] fold_full(logic [31:0] h, logic [31:0] k);
        logic [31:0] m;
        m = k * mm2_pkg::MIX_MUL;
        m = m ^ (m >> mm2_pkg::MIX_SHIFT);
        m = m * mm2_pkg::MIX_MUL;
        return (h * mm2_pkg::MIX_MUL) ^ m;
    endfunction

    function automatic logic [31:0] fold_tail(logic [31:0] h, logic [31:0] w, logic [2:0] n);
        logic [31:0] mask;
        mask = (n == 3'd1) ? 32'h0000_00FF : (n == 3'd2) ? 32'h0000_FFFF : 32'h00FF_FFFF;
        return (h ^ (w & mask)) * mm2_pkg::MIX_MUL;
    endfunction

    function automatic logic [31:0] hash_finish(logic [31:0] h);
        logic [31:0] f;
        f = h ^ (h >> mm2_pkg::FIN_SHIFT_A);
        f = f * mm2_pkg::MIX_MUL;
        return f ^ (f >> mm2_pkg::FIN_SHIFT_B);
    endfunction

    task automatic offer_word(input logic [31:0] w, input logic [2:0] n, input logic f,
                              input logic l, input logic [30:0] len, input logic typed,
                              input logic [31:0] typed_hash);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        key_word   <= w;
        byte_count <= n;
        first_word <= f;
        last_word  <= l;
        key_length <= len;
        do
            @(posedge clk);
        while (in_stall);
        if (f)
            hash_acc = seed_model ^ {1'b0, len};
        if (n >= mm2_pkg::FULL_COUNT)
            hash_acc = fold_full(hash_acc, w);
        else if (n != 3'd0)
            hash_acc = fold_tail(hash_acc, w, n);
        if (l)
            hash_due.insert(hash_due.size(), typed ? typed_hash : hash_finish(hash_acc));
    endtask

    task automatic await_hashes();
        in_valid <= 1'b0;
        while (hash_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        cfg_valid <= 1'b1;
        seed      <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        seed_model = v;
    endtask

    task automatic run_keys(input int n_items);
        int          sent;
        int          len;
        int          n_words;
        int          kind;
        int          i;
        logic [30:0] len_field;
        logic [2:0]  n;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 80)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 400)
                                                  : $urandom_range(0, 24);
                if (len == 0)
                begin
                    offer_word($urandom, 3'd0, 1'b1, 1'b1, 31'd0, 1'b0, '0);
                    sent++;
                end
                else
                begin
                    n_words = (len + 3) / 4;
                    for (i = 0; i < n_words; i++)
                    begin
                        n = (len - 4 * i >= 4) ? 3'd4 : 3'(len - 4 * i);
                        offer_word($urandom, n, i == 0, i == n_words - 1, 31'(len),
                                   1'b0, '0);
                    end
                    sent += n_words;
                end
            end
            else if (kind < 90)
            begin
                len_field = 31'($urandom);
                n_words = $urandom_range(1, 4);
                for (i = 0; i < n_words; i++)
                    offer_word($urandom, 3'd4, i == 0, i == n_words - 1, len_field,
                               1'b0, '0);
                sent += n_words;
            end
            else
            begin
                offer_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom),
                           1'($urandom), 31'($urandom), 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_out_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_out_req = 1'b0;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (hash_due.size() == 0)
            begin
                $display("%0t: unexpected hash_value %h", $time, hash_value);
                fails++;
            end
            else
            begin
                hash_want = hash_due.pop_front();
                if (hash_value !== hash_want)
                begin
                    $display("%0t: hash_value mismatch: expected %h, got %h",
                             $time, hash_want, hash_value);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct   = 31;
        recv_stall_pct = 69;
        foreach (dir_reqs[i])
            offer_word(dir_reqs[i].word, dir_reqs[i].count, dir_reqs[i].first,
                       dir_reqs[i].last, dir_reqs[i].len, dir_reqs[i].typed,
                       dir_reqs[i].hash);
        await_hashes();

        write_seed(32'hFFFF_FFFF);
        foreach (dir_reqs[i])
            offer_word(dir_reqs[i].word, dir_reqs[i].count, dir_reqs[i].first,
                       dir_reqs[i].last, dir_reqs[i].len, 1'b0, '0);
        await_hashes();

        // hold the output long enough to back the block up
        write_seed($urandom);
        hold_out_req = 1'b1;
        run_keys(250);
        await_hashes();
        write_seed(32'h0000_0000);
        run_keys(250);
        await_hashes();

        send_gap_pct   = 69;
        recv_stall_pct = 31;
        write_seed(32'h8000_0000);
        run_keys(250);
        await_hashes();
        write_seed($urandom);
        run_keys(250);
        await_hashes();

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        write_seed(32'hFFFF_FFFF);
        run_keys(250);
        await_hashes();
        write_seed(32'h0000_0001);
        run_keys(250);
        await_hashes();

        if (fails == 0 && hash_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== murmur2_hash_stream.f =====
rtl/mm2_pkg.sv
rtl/mm2_datapath.sv
rtl/mm2_ctrl.sv
rtl/murmur2_hash_stream.sv
tb/sv/tb_top.sv
